// ===== rtl/inv3_pkg.sv =====
// ----------------------------------------------------------------------------
// inv3_pkg
// Shared widths, types and cofactor index tables for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
`default_nettype none
package inv3_pkg;
  localparam int NEL        = 9;
  localparam int DIN_W      = 16;
  localparam int PROD_W     = 32;
  localparam int COF_W      = 33;
  localparam int DET_W      = 51;
  localparam int MAG_W      = 32;
  localparam int DEN_W      = 50;
  localparam int NUM_W      = 61;
  localparam int QW         = 33;
  localparam int CMP_W      = DEN_W + QW;
  localparam int OUT_W      = 32;
  localparam int SHIFT      = 28;
  localparam int IN_DATA_W  = NEL * DIN_W;
  localparam int OUT_DATA_W = NEL * OUT_W;
  localparam int FIFO_DEPTH = 4;

  localparam logic signed [OUT_W-1:0] Q16_ONE = OUT_W'(65536);
  localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // cofactor k = m[PA]*m[PB] - m[NA]*m[NB]
  localparam int PA [NEL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [NEL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int NA [NEL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int NB [NEL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  // determinant terms: row 0 times first column of the adjugate
  localparam int CI [3] = '{0, 3, 6};

  typedef logic signed [COF_W-1:0] cof_t;

  typedef struct packed {
    cof_t [NEL-1:0]          cof;
    logic signed [DET_W-1:0] det;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/inv3_front.sv =====
// ----------------------------------------------------------------------------
// inv3_front
// Accepts matrices, forms the nine cofactors and the determinant in four
// pipeline stages and pushes them into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none
module inv3_front import inv3_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  output logic                      push,
  output job_t                      job,
  input  wire logic                 full
);
  logic en;
  logic v1, v2, v3, v4;
  logic signed [DIN_W-1:0] m [NEL];
  logic signed [PROD_W-1:0] pp [NEL];
  logic signed [PROD_W-1:0] pn [NEL];
  logic signed [DIN_W-1:0] abc1 [3];
  logic signed [DIN_W-1:0] abc2 [3];
  cof_t adj2 [NEL];
  cof_t adj3 [NEL];
  cof_t [NEL-1:0] adj4;
  logic signed [DET_W-1:0] t3 [3];
  logic signed [DET_W-1:0] det4;

  assign en       = !(v4 && full);
  assign s_tready = en;
  assign push     = v4 && !full;
  assign job.cof  = adj4;
  assign job.det  = det4;

  always_comb begin
    for (int k = 0; k < NEL; k++) begin
      m[k] = s_tdata[k*DIN_W +: DIN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NEL; k++) begin
        pp[k]   <= m[PA[k]] * m[PB[k]];
        pn[k]   <= m[NA[k]] * m[NB[k]];
        adj2[k] <= COF_W'(pp[k]) - COF_W'(pn[k]);
        adj3[k] <= adj2[k];
        adj4[k] <= adj3[k];
      end
      for (int j = 0; j < 3; j++) begin
        abc1[j] <= m[j];
        abc2[j] <= abc1[j];
        t3[j]   <= abc2[j] * adj2[CI[j]];
      end
      det4 <= t3[0] + t3[1] + t3[2];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/inv3_fifo.sv =====
// ----------------------------------------------------------------------------
// inv3_fifo
// Short job queue between the front and the back pipelines.
// ----------------------------------------------------------------------------
`default_nettype none
module inv3_fifo import inv3_pkg::*; #(
  parameter int Depth = FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wdata,
  output logic      full,
  input  wire logic pop,
  output job_t      rdata,
  output logic      empty
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t mem [Depth];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic do_push, do_pop;

  assign full    = (count == CW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/inv3_back.sv =====
// ----------------------------------------------------------------------------
// inv3_back
// Divides the nine cofactors by the determinant with a one bit per stage
// restoring divider, then rounds, saturates and drives the result stream.
// ----------------------------------------------------------------------------
`default_nettype none
module inv3_back import inv3_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  empty,
  input  wire job_t                  job,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic [1:0]                 m_tuser
);
  localparam logic [QW-1:0] NEG_LIM = QW'($unsigned(SAT_MIN));
  localparam logic [QW-1:0] POS_LIM = QW'($unsigned(SAT_MAX));

  logic en;
  logic va;
  logic [NUM_W-1:0] na [NEL];
  logic [DEN_W-1:0] dena;
  logic nega [NEL];
  logic singa;

  logic v [QW+1];
  logic [NUM_W-1:0] rem [QW+1][NEL];
  logic [QW-1:0] q [QW+1][NEL];
  logic ng [QW+1][NEL];
  logic ov [QW+1][NEL];
  logic [DEN_W-1:0] den [QW+1];
  logic sg [QW+1];

  logic signed [OUT_W-1:0] r [NEL];
  logic singular, saturated;
  logic sat_any;

  logic [COF_W-1:0] cm [NEL];
  logic [DET_W-1:0] dm;

  assign en       = !m_tvalid || m_tready;
  assign pop      = en && !empty;
  assign m_tuser  = {saturated, singular};

  always_comb begin
    for (int k = 0; k < NEL; k++) begin
      m_tdata[k*OUT_W +: OUT_W] = r[k];
    end
  end

  // magnitudes of the job at the queue head
  always_comb begin
    dm = job.det[DET_W-1] ? -job.det : job.det;
    for (int k = 0; k < NEL; k++) begin
      cm[k] = job.cof[k][COF_W-1] ? -job.cof[k] : job.cof[k];
    end
  end

  // any element clamped at the last divider stage
  always_comb begin
    sat_any = 1'b0;
    for (int k = 0; k < NEL; k++) begin
      if (ng[QW][k] && (ov[QW][k] || q[QW][k] != '0)) begin
        if (ov[QW][k] || q[QW][k] > NEG_LIM) begin
          sat_any = 1'b1;
        end
      end else begin
        if (ov[QW][k] || q[QW][k] > POS_LIM) begin
          sat_any = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      m_tvalid <= 1'b0;
      for (int s = 0; s <= QW; s++) begin
        v[s] <= 1'b0;
      end
    end else if (en) begin
      va   <= !empty;
      v[0] <= va;
      for (int s = 0; s < QW; s++) begin
        v[s+1] <= v[s];
      end
      m_tvalid <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dena  <= DEN_W'(dm);
      singa <= (job.det == '0);
      for (int k = 0; k < NEL; k++) begin
        na[k]   <= (NUM_W'(cm[k]) << SHIFT) + NUM_W'(dm >> 1);
        nega[k] <= job.cof[k][COF_W-1] ^ job.det[DET_W-1];
      end

      den[0] <= dena;
      sg[0]  <= singa;
      for (int k = 0; k < NEL; k++) begin
        rem[0][k] <= na[k];
        q[0][k]   <= '0;
        ng[0][k]  <= nega[k];
        ov[0][k]  <= CMP_W'(na[k]) >= (CMP_W'(dena) << QW);
      end

      for (int s = 0; s < QW; s++) begin
        den[s+1] <= den[s];
        sg[s+1]  <= sg[s];
        for (int k = 0; k < NEL; k++) begin
          ng[s+1][k] <= ng[s][k];
          ov[s+1][k] <= ov[s][k];
          if (CMP_W'(rem[s][k]) >= (CMP_W'(den[s]) << (QW - 1 - s))) begin
            rem[s+1][k] <= NUM_W'(CMP_W'(rem[s][k]) - (CMP_W'(den[s]) << (QW - 1 - s)));
            q[s+1][k]   <= {q[s][k][QW-2:0], 1'b1};
          end else begin
            rem[s+1][k] <= rem[s][k];
            q[s+1][k]   <= {q[s][k][QW-2:0], 1'b0};
          end
        end
      end

      singular <= sg[QW];
      for (int k = 0; k < NEL; k++) begin
        if (sg[QW]) begin
          r[k] <= (k == 0 || k == 4 || k == 8) ? Q16_ONE : '0;
        end else if (ng[QW][k] && (ov[QW][k] || q[QW][k] != '0)) begin
          if (ov[QW][k] || q[QW][k] > NEG_LIM) begin
            r[k] <= SAT_MIN;
          end else begin
            r[k] <= -OUT_W'(q[QW][k]);
          end
        end else begin
          if (ov[QW][k] || q[QW][k] > POS_LIM) begin
            r[k] <= SAT_MAX;
          end else begin
            r[k] <= OUT_W'(q[QW][k]);
          end
        end
      end
      saturated <= sat_any && !sg[QW];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/invert_matrix3x3.sv =====
// ----------------------------------------------------------------------------
// invert_matrix3x3
// Inverse of a 3x3 Q4.12 matrix by the adjugate, Q16.16 saturated result.
// ----------------------------------------------------------------------------
// channel  dir  tdata                      tuser
// s_axis   in   m00..m22, 16 bit each      -
// m_axis   out  r00..r22, 32 bit each      singular, saturated
//
// one matrix per cycle sustained unless the output stalls; a matrix passes the
// front stages, the queue, the setup registers, 33 divider stages (one quotient
// bit each) and the output register. reset clears valid and queue state only. an
// output stall holds the back pipeline; the queue absorbs the front until it fills.
// ----------------------------------------------------------------------------
`default_nettype none
module invert_matrix3x3 import inv3_pkg::*; #(
  parameter int FifoDepth = FIFO_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // m00 m01 m02 m10 m11 m12 m20 m21 m22
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,  // r00 r01 r02 r10 r11 r12 r20 r21 r22
  output logic [1:0]                 m_tuser   // singular saturated
);
  logic push, full, pop, empty;
  job_t wjob, rjob;

  inv3_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .push(push), .job(wjob), .full(full)
  );

  inv3_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(wjob), .full(full),
    .pop(pop), .rdata(rjob), .empty(empty)
  );

  inv3_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .job(rjob), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );
endmodule
`default_nettype wire
